### design/stack_accumulator_vm_core_assert.svh
// ----------------------------------------------------------------------------
// stack_accumulator_vm_core_assert.svh
// Assertion macros used by the checker of the stack-accumulator core.
// ----------------------------------------------------------------------------
`ifndef STACK_ACCUMULATOR_VM_CORE_ASSERT_SVH
`define STACK_ACCUMULATOR_VM_CORE_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet while arst_n is low
`define SAV_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, quiet while arst_n is low
`define SAV_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/sav_pkg.sv
// ----------------------------------------------------------------------------
// sav_pkg
// Shared types and constants of the stack-accumulator execution core.
// ----------------------------------------------------------------------------
package sav_pkg;

	localparam int unsigned STACK_BYTES_DEF = 16384;
	localparam int unsigned MEM_BYTES_DEF   = 65536;
	localparam int unsigned WORD_BYTES      = 4;
	localparam int unsigned BYTE_BITS       = 8;
	localparam int unsigned DATA_W          = 32;
	localparam int unsigned PTR_W           = 16;

	typedef enum logic [3:0] {
		OP_LOAD  = 4'd0,
		OP_FETCH = 4'd1,
		OP_PTR   = 4'd2,
		OP_PUSH  = 4'd3,
		OP_JUMP  = 4'd4,
		OP_CALL  = 4'd5,
		OP_RET   = 4'd6,
		OP_POP   = 4'd7,
		OP_ADD   = 4'd8,
		OP_SUB   = 4'd9,
		OP_MUL   = 4'd10,
		OP_DIV   = 4'd11,
		OP_PUTC  = 4'd12,
		OP_PUTI  = 4'd13,
		OP_CMP   = 4'd14
	} op_t;

	typedef enum logic [1:0] {
		PRINT_NONE = 2'd0,
		PRINT_CHAR = 2'd1,
		PRINT_NUM  = 2'd2
	} print_t;

	typedef enum logic [1:0] {
		FAULT_OK        = 2'd0,
		FAULT_DIV_ZERO  = 2'd1,
		FAULT_UNDERFLOW = 2'd2,
		FAULT_OVERFLOW  = 2'd3
	} fault_t;

	// pointer-move modes
	localparam logic [2:0] PM_SP_FROM_BP  = 3'd0;
	localparam logic [2:0] PM_BP_FROM_SP  = 3'd1;
	localparam logic [2:0] PM_ACC_FROM_BP = 3'd2;
	localparam logic [2:0] PM_POP_BP      = 3'd3;

	// compare modes
	localparam logic [2:0] CMP_NZ = 3'd0;
	localparam logic [2:0] CMP_LT = 3'd1;
	localparam logic [2:0] CMP_LE = 3'd2;
	localparam logic [2:0] CMP_EQ = 3'd3;

	// classified operation handed from front to back
	typedef struct packed {
		op_t               op;
		logic [DATA_W-1:0] imm;
		logic [2:0]        mode;
		logic              pops;
		logic              pushes;
		logic [DATA_W-1:0] mask;
	} cmd_t;

	typedef struct packed {
		logic              start;
		logic [DATA_W-1:0] dividend;
		logic [DATA_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DATA_W-1:0] quot;
	} div_rsp_t;

endpackage

### design/sav_ram.sv
// ----------------------------------------------------------------------------
// sav_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module sav_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

### design/sav_div.sv
// ----------------------------------------------------------------------------
// sav_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sav_div (
	input  logic               clk,
	input  logic               arst_n,
	input  sav_pkg::div_req_t  req,
	output sav_pkg::div_rsp_t  rsp
);
	import sav_pkg::*;

	localparam int unsigned CNT_W = $clog2(DATA_W + 1);

	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] quo_q;
	logic [DATA_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W+1:0] diff;

	// trial subtraction
	assign shifted = {rem_q, quo_q[DATA_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, dvs_q};

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and quotient
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[DATA_W+1]) begin
				rem_q <= diff[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DATA_W-1:0];
				quo_q <= {quo_q[DATA_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

### design/sav_front.sv
// ----------------------------------------------------------------------------
// sav_front
// Accepts operation beats, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module sav_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op_valid,
	output logic          op_stall,
	input  logic [3:0]    opcode,
	input  logic [31:0]   immediate,
	input  logic [2:0]    sub_mode,
	output logic          cmd_valid,
	output sav_pkg::cmd_t cmd,
	input  logic          cmd_pop
);
	import sav_pkg::*;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	cmd_t              dec;
	op_t               op;
	cmd_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;

	// classification
	always_comb begin
		op         = op_t'(opcode);
		dec.op     = op;
		dec.imm    = immediate;
		dec.mode   = sub_mode;
		dec.pushes = (op == OP_PUSH) || (op == OP_CALL);
		dec.pops   = ((op == OP_PTR) && (sub_mode == PM_POP_BP)) || (op == OP_RET) ||
			(op == OP_POP) || (op == OP_ADD) || (op == OP_SUB) || (op == OP_MUL) ||
			(op == OP_DIV);
		// fetch byte count mask, counts above four act as four
		case (sub_mode)
			3'd0: dec.mask = 32'h0000_0000;
			3'd1: dec.mask = 32'h0000_00ff;
			3'd2: dec.mask = 32'h0000_ffff;
			3'd3: dec.mask = 32'h00ff_ffff;
			default: dec.mask = 32'hffff_ffff;
		endcase
	end

	assign op_stall  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign push      = op_valid && !op_stall;
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = entry_q[rd_ptr_q];

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && cmd_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= dec;
		end
	end

endmodule

### design/sav_back.sv
// ----------------------------------------------------------------------------
// sav_back
// Executes classified operations against the machine state and byte memory.
// ----------------------------------------------------------------------------
module sav_back #(
	parameter int unsigned STACK_BYTES = sav_pkg::STACK_BYTES_DEF,
	parameter int unsigned MEM_BYTES   = sav_pkg::MEM_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  sav_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          res_valid,
	input  logic          res_stall,
	output logic [31:0]   accum_value,
	output logic [15:0]   program_counter,
	output logic [15:0]   stack_pointer,
	output logic [15:0]   base_pointer,
	output logic          skip_pending,
	output logic [1:0]    print_kind,
	output logic [1:0]    fault
);
	import sav_pkg::*;

	localparam int unsigned AW       = $clog2(MEM_BYTES);
	localparam bit          MEM_POW2 = (MEM_BYTES & (MEM_BYTES - 1)) == 0;
	localparam logic [DATA_W-1:0] RECIP =
		DATA_W'((64'd1 << DATA_W) / 64'(MEM_BYTES));

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADDR,
		ST_AWAIT,
		ST_READ,
		ST_WRITE,
		ST_EXEC,
		ST_DIVW,
		ST_FIN
	} state_t;

	state_t            state_q;
	cmd_t              cur_q;
	logic [DATA_W-1:0] acc_q;
	logic [PTR_W-1:0]  pc_q;
	logic [PTR_W-1:0]  sp_q;
	logic [PTR_W-1:0]  bp_q;
	logic              skip_q;
	logic [DATA_W-1:0] word_q;
	logic [DATA_W-1:0] araw_q;
	logic [DATA_W-1:0] qest_q;
	logic [AW-1:0]     addr_q;
	logic [2:0]        cnt_q;
	print_t            print_q;
	fault_t            fault_q;

	logic              res_valid_q;
	logic [DATA_W-1:0] res_acc_q;
	logic [PTR_W-1:0]  res_pc_q;
	logic [PTR_W-1:0]  res_sp_q;
	logic [PTR_W-1:0]  res_bp_q;
	logic              res_skip_q;
	print_t            res_print_q;
	fault_t            res_fault_q;

	logic              pop_ok;
	logic              push_ok;
	logic [PTR_W-1:0]  below;
	logic [PTR_W-1:0]  sp_up;
	logic [DATA_W-1:0] ret_addr;
	logic [PTR_W-1:0]  jump_pc;
	logic [AW-1:0]     addr_next;
	logic              cmp_hit;
	logic              na;
	logic              nb;
	logic [DATA_W-1:0] ma;
	logic [DATA_W-1:0] mb;
	logic [DATA_W-1:0] mul_lo;
	logic [2*DATA_W-1:0] recip_prod;
	logic [DATA_W-1:0] red_sub;
	logic [DATA_W-1:0] araw_fix;
	logic              ram_we;
	logic [BYTE_BITS-1:0] ram_wdata;
	logic [BYTE_BITS-1:0] ram_rdata;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	// stack limits and pointer arithmetic
	assign pop_ok   = sp_q >= PTR_W'(WORD_BYTES);
	assign push_ok  = ({1'b0, sp_q} + (PTR_W+1)'(WORD_BYTES)) <= (PTR_W+1)'(STACK_BYTES);
	assign below    = sp_q - PTR_W'(WORD_BYTES);
	assign sp_up    = sp_q + PTR_W'(WORD_BYTES);
	assign ret_addr = DATA_W'(pc_q) + DATA_W'(WORD_BYTES);
	assign jump_pc  = skip_q ? (pc_q + PTR_W'(WORD_BYTES))
		: (PTR_W'(STACK_BYTES) + cur_q.imm[PTR_W-1:0]);
	assign addr_next = (addr_q == AW'(MEM_BYTES - 1)) ? '0 : (addr_q + 1'b1);

	// address reduction by reciprocal: quotient estimate is at most one short
	assign recip_prod = {{DATA_W{1'b0}}, araw_q} * {{DATA_W{1'b0}}, RECIP};
	assign red_sub    = qest_q * DATA_W'(MEM_BYTES);
	assign araw_fix   = (araw_q >= DATA_W'(MEM_BYTES)) ? (araw_q - DATA_W'(MEM_BYTES))
		: araw_q;

	// compare condition on the signed accumulator
	always_comb begin
		case (cmd.mode)
			CMP_NZ: cmp_hit = (acc_q != '0);
			CMP_LT: cmp_hit = acc_q[DATA_W-1];
			CMP_LE: cmp_hit = acc_q[DATA_W-1] || (acc_q == '0);
			CMP_EQ: cmp_hit = (acc_q == '0);
			default: cmp_hit = 1'b0;
		endcase
	end

	// signed division operands as magnitudes
	assign na     = acc_q[DATA_W-1];
	assign nb     = word_q[DATA_W-1];
	assign ma     = na ? (DATA_W'(0) - acc_q) : acc_q;
	assign mb     = nb ? (DATA_W'(0) - word_q) : word_q;
	assign mul_lo = acc_q * word_q;

	// divider for the divide operation
	always_comb begin
		div_req.start    = (state_q == ST_EXEC) && (cur_q.op == OP_DIV) && (word_q != '0);
		div_req.dividend = ma;
		div_req.divisor  = mb;
	end

	sav_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// byte memory, swept to zero after reset
	assign ram_we    = (state_q == ST_CLEAR) || (state_q == ST_WRITE);
	assign ram_wdata = (state_q == ST_CLEAR) ? '0 : word_q[BYTE_BITS-1:0];

	sav_ram #(
		.WIDTH (BYTE_BITS),
		.DEPTH (MEM_BYTES)
	) u_mem (
		.clk   (clk),
		.we    (ram_we),
		.addr  (addr_q),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign cmd_pop = (state_q == ST_IDLE) && cmd_valid;

	// sequencer, machine state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cur_q       <= '0;
			acc_q       <= '0;
			pc_q        <= PTR_W'(STACK_BYTES);
			sp_q        <= '0;
			bp_q        <= '0;
			skip_q      <= 1'b0;
			word_q      <= '0;
			araw_q      <= '0;
			qest_q      <= '0;
			addr_q      <= '0;
			cnt_q       <= '0;
			print_q     <= PRINT_NONE;
			fault_q     <= FAULT_OK;
			res_valid_q <= 1'b0;
			res_acc_q   <= '0;
			res_pc_q    <= '0;
			res_sp_q    <= '0;
			res_bp_q    <= '0;
			res_skip_q  <= 1'b0;
			res_print_q <= PRINT_NONE;
			res_fault_q <= FAULT_OK;
		end else begin
			if (res_valid_q && !res_stall && (state_q != ST_FIN)) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					addr_q <= addr_next;
					if (addr_q == AW'(MEM_BYTES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						cur_q   <= cmd;
						print_q <= PRINT_NONE;
						fault_q <= FAULT_OK;
						cnt_q   <= '0;
						state_q <= ST_FIN;
						if (cmd.pops && !pop_ok) begin
							fault_q <= FAULT_UNDERFLOW;
						end else if (cmd.pushes && !push_ok) begin
							fault_q <= FAULT_OVERFLOW;
						end else begin
							case (cmd.op)
								OP_LOAD: acc_q <= cmd.imm;
								OP_FETCH: begin
									araw_q  <= acc_q;
									state_q <= ST_ADDR;
								end
								OP_PTR: begin
									case (cmd.mode)
										PM_SP_FROM_BP:  sp_q  <= bp_q;
										PM_BP_FROM_SP:  bp_q  <= sp_q;
										PM_ACC_FROM_BP: acc_q <= DATA_W'(bp_q);
										PM_POP_BP: begin
											araw_q  <= DATA_W'(below);
											state_q <= ST_ADDR;
										end
										default: ;
									endcase
								end
								OP_PUSH: begin
									araw_q  <= DATA_W'(sp_q);
									word_q  <= acc_q;
									state_q <= ST_ADDR;
								end
								OP_JUMP: begin
									skip_q <= 1'b0;
									pc_q   <= skip_q ? (pc_q + PTR_W'(WORD_BYTES))
										: (PTR_W'(STACK_BYTES) + cmd.imm[PTR_W-1:0]);
								end
								OP_CALL: begin
									acc_q   <= ret_addr;
									word_q  <= ret_addr;
									araw_q  <= DATA_W'(sp_q);
									state_q <= ST_ADDR;
								end
								OP_RET, OP_POP, OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
									araw_q  <= DATA_W'(below);
									state_q <= ST_ADDR;
								end
								OP_PUTC: print_q <= PRINT_CHAR;
								OP_PUTI: print_q <= PRINT_NUM;
								OP_CMP: begin
									if (cmp_hit) begin
										skip_q <= 1'b1;
									end
								end
								default: ;
							endcase
						end
					end
				end
				ST_ADDR: begin
					if (MEM_POW2) begin
						addr_q  <= araw_q[AW-1:0];
						state_q <= cur_q.pushes ? ST_WRITE : ST_READ;
					end else begin
						qest_q  <= recip_prod[2*DATA_W-1:DATA_W];
						state_q <= ST_AWAIT;
					end
				end
				ST_AWAIT: begin
					// remainder estimate, then two corrective subtractions
					case (cnt_q)
						3'd0: begin
							araw_q <= araw_q - red_sub;
							cnt_q  <= 3'd1;
						end
						3'd1: begin
							araw_q <= araw_fix;
							cnt_q  <= 3'd2;
						end
						default: begin
							addr_q  <= araw_fix[AW-1:0];
							cnt_q   <= '0;
							state_q <= cur_q.pushes ? ST_WRITE : ST_READ;
						end
					endcase
				end
				ST_READ: begin
					// one byte address per cycle, data back in the cycle after its address
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q != 3'(WORD_BYTES)) begin
						addr_q <= addr_next;
					end
					if (cnt_q != '0) begin
						word_q <= {ram_rdata, word_q[DATA_W-1:BYTE_BITS]};
					end
					if (cnt_q == 3'(WORD_BYTES)) begin
						state_q <= ST_EXEC;
					end
				end
				ST_WRITE: begin
					cnt_q  <= cnt_q + 1'b1;
					addr_q <= addr_next;
					word_q <= {BYTE_BITS'(0), word_q[DATA_W-1:BYTE_BITS]};
					if (cnt_q == 3'(WORD_BYTES - 1)) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_FIN;
					case (cur_q.op)
						OP_FETCH: acc_q <= word_q & cur_q.mask;
						OP_PTR: begin
							sp_q <= below;
							bp_q <= word_q[PTR_W-1:0];
						end
						OP_PUSH: sp_q <= sp_up;
						OP_CALL: begin
							sp_q   <= sp_up;
							pc_q   <= jump_pc;
							skip_q <= 1'b0;
						end
						OP_RET: begin
							sp_q <= below;
							pc_q <= word_q[PTR_W-1:0];
						end
						OP_POP: begin
							sp_q  <= below;
							acc_q <= word_q;
						end
						OP_ADD: begin
							sp_q  <= below;
							acc_q <= acc_q + word_q;
						end
						OP_SUB: begin
							sp_q  <= below;
							acc_q <= acc_q - word_q;
						end
						OP_MUL: begin
							sp_q  <= below;
							acc_q <= mul_lo;
						end
						OP_DIV: begin
							if (word_q == '0) begin
								fault_q <= FAULT_DIV_ZERO;
							end else begin
								sp_q    <= below;
								state_q <= ST_DIVW;
							end
						end
						default: ;
					endcase
				end
				ST_DIVW: begin
					if (div_rsp.done) begin
						acc_q   <= (na != nb) ? (DATA_W'(0) - div_rsp.quot) : div_rsp.quot;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!res_valid_q || !res_stall) begin
						res_valid_q <= 1'b1;
						res_acc_q   <= acc_q;
						res_pc_q    <= pc_q;
						res_sp_q    <= sp_q;
						res_bp_q    <= bp_q;
						res_skip_q  <= skip_q;
						res_print_q <= print_q;
						res_fault_q <= fault_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign res_valid       = res_valid_q;
	assign accum_value     = res_acc_q;
	assign program_counter = res_pc_q;
	assign stack_pointer   = res_sp_q;
	assign base_pointer    = res_bp_q;
	assign skip_pending    = res_skip_q;
	assign print_kind      = res_print_q;
	assign fault           = res_fault_q;

endmodule

### design/stack_accumulator_vm_core.sv
// ----------------------------------------------------------------------------
// stack_accumulator_vm_core
// Execution core of a stack-accumulator machine, one decoded operation a beat.
// ----------------------------------------------------------------------------
// usage
//   operation channel: op_valid / op_stall with opcode, immediate, sub_mode;
//   a beat moves when op_valid is high and op_stall low. a two-entry queue
//   sits behind it, so the sender is stalled only when the queue is full.
//   result channel: res_valid / res_stall, one result beat per operation, in
//   order, held steady while res_stall is high. the queue keeps taking
//   operations while a result waits; the back end holds its next result
//   until the waiting one has gone.
//   load, pointer moves without memory, jump, print and compare complete
//   without memory access; a stack or fetch access walks the byte memory
//   one byte per cycle, storing or loading a word; divide then waits for
//   the bit-serial divider. with a memory size that is not a power of two
//   every memory access first passes through address reduction. the back
//   end takes no new operation until the current result is registered.
//   reset: state returns to its start values and the byte memory is swept to
//   zero, during which no operation leaves the queue.
// ----------------------------------------------------------------------------
module stack_accumulator_vm_core #(
	parameter int unsigned STACK_BYTES = sav_pkg::STACK_BYTES_DEF,
	parameter int unsigned MEM_BYTES   = sav_pkg::MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        op_valid,
	output logic        op_stall,
	input  logic [3:0]  opcode,
	input  logic [31:0] immediate,
	input  logic [2:0]  sub_mode,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [31:0] accum_value,
	output logic [15:0] program_counter,
	output logic [15:0] stack_pointer,
	output logic [15:0] base_pointer,
	output logic        skip_pending,
	output logic [1:0]  print_kind,
	output logic [1:0]  fault
);
	import sav_pkg::*;

	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	// front end: accept and classify
	sav_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op_stall  (op_stall),
		.opcode    (opcode),
		.immediate (immediate),
		.sub_mode  (sub_mode),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// back end: execute
	sav_back #(
		.STACK_BYTES (STACK_BYTES),
		.MEM_BYTES   (MEM_BYTES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd),
		.cmd_pop         (cmd_pop),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.accum_value     (accum_value),
		.program_counter (program_counter),
		.stack_pointer   (stack_pointer),
		.base_pointer    (base_pointer),
		.skip_pending    (skip_pending),
		.print_kind      (print_kind),
		.fault           (fault)
	);

endmodule

### design/sav_checker.sv
// ----------------------------------------------------------------------------
// sav_checker
// Port-level checks of the stack-accumulator core, bound to the top level.
// ----------------------------------------------------------------------------
`include "stack_accumulator_vm_core_assert.svh"

module sav_checker #(
	parameter int unsigned STACK_BYTES = sav_pkg::STACK_BYTES_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        res_valid,
	input logic        res_stall,
	input logic [31:0] accum_value,
	input logic [15:0] stack_pointer,
	input logic [1:0]  fault
);
	import sav_pkg::*;

	// stalled result beat is held
	`SAV_ASSERT_NXT(a_res_hold, res_valid && res_stall, res_valid && $stable(accum_value) && $stable(stack_pointer) && $stable(fault), "stalled result beat changed")

	// underflow only reported with fewer than a word on the stack
	`SAV_ASSERT_IMP(a_underflow, res_valid && (fault == FAULT_UNDERFLOW), stack_pointer < 16'(WORD_BYTES), "underflow with a word on the stack")

	// overflow only reported when a word does not fit
	`SAV_ASSERT_IMP(a_overflow, res_valid && (fault == FAULT_OVERFLOW), ({1'b0, stack_pointer} + 17'(WORD_BYTES)) > 17'(STACK_BYTES), "overflow with room on the stack")

	// divide by zero leaves the divisor on the stack
	`SAV_ASSERT_IMP(a_div_zero, res_valid && (fault == FAULT_DIV_ZERO), stack_pointer >= 16'(WORD_BYTES), "divide by zero with empty stack")

endmodule

bind stack_accumulator_vm_core sav_checker #(.STACK_BYTES(STACK_BYTES)) u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.res_valid     (res_valid),
	.res_stall     (res_stall),
	.accum_value   (accum_value),
	.stack_pointer (stack_pointer),
	.fault         (fault)
);

### tb/stack_accumulator_vm_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_accumulator_vm_core_tb
// Drives decoded operations into the stack-accumulator core and compares
// every result beat with a behavioural model of the machine state and memory.
// ----------------------------------------------------------------------------
module stack_accumulator_vm_core_tb;
	import sav_pkg::*;

	localparam int unsigned STK = STACK_BYTES_DEF;

	typedef struct packed {
		logic [31:0] acc;
		logic [15:0] pc;
		logic [15:0] sp;
		logic [15:0] bp;
		logic        skip;
		print_t      prn;
		fault_t      flt;
	} vm_res_t;

	// scoreboard: machine model plus queue of expected result beats
	class vm_scoreboard;
		logic [31:0] acc;
		logic [15:0] bp, sp, pc;
		logic        skip;
		logic [7:0]  mem [int];
		vm_res_t     pending [$];
		int          errors, beats;

		function new();
			acc = '0; bp = '0; sp = '0; pc = STK[15:0]; skip = 1'b0;
			errors = 0; beats = 0;
		endfunction

		function logic [31:0] rd_word(logic [31:0] a);
			logic [31:0] v;
			logic [15:0] ad;
			v = '0;
			for (int i = 0; i < 4; i++) begin
				ad = a[15:0] + 16'(i);
				if (mem.exists(ad)) v[8*i +: 8] = mem[ad];
			end
			return v;
		endfunction

		function void wr_word(logic [31:0] a, logic [31:0] v);
			logic [15:0] ad;
			for (int i = 0; i < 4; i++) begin
				ad = a[15:0] + 16'(i);
				mem[ad] = v[8*i +: 8];
			end
		endfunction

		// note an accepted operation and queue its result
		function void note_op(logic [3:0] op, logic [31:0] imm, logic [2:0] md);
			vm_res_t r;
			logic can_pop, can_push;
			logic [15:0] below;
			logic [31:0] w, mask, ma, mb, q;
			int unsigned n;
			r.prn = PRINT_NONE;
			r.flt = FAULT_OK;
			can_pop = sp >= 16'd4;
			can_push = (32'(sp) + 32'd4) <= STK;
			below = sp - 16'd4;
			case (op)
				OP_LOAD: acc = imm;
				OP_FETCH: begin
					n = (md > 3'd4) ? 4 : int'(md);
					mask = (n >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * n)) - 32'd1);
					acc = rd_word(acc) & mask;
				end
				OP_PTR: begin
					if (md == PM_SP_FROM_BP) sp = bp;
					else if (md == PM_BP_FROM_SP) bp = sp;
					else if (md == PM_ACC_FROM_BP) acc = {16'd0, bp};
					else if (md == PM_POP_BP) begin
						if (!can_pop) r.flt = FAULT_UNDERFLOW;
						else begin
							sp = below;
							w = rd_word(below);
							bp = w[15:0];
						end
					end
				end
				OP_PUSH: begin
					if (!can_push) r.flt = FAULT_OVERFLOW;
					else begin
						wr_word(sp, acc);
						sp = sp + 16'd4;
					end
				end
				OP_JUMP, OP_CALL: begin
					if (op == OP_CALL && !can_push) r.flt = FAULT_OVERFLOW;
					else begin
						if (op == OP_CALL) begin
							acc = 32'(pc) + 32'd4;
							wr_word(sp, acc);
							sp = sp + 16'd4;
						end
						if (skip) begin
							skip = 1'b0;
							pc = pc + 16'd4;
						end else pc = STK[15:0] + imm[15:0];
					end
				end
				OP_RET: begin
					if (!can_pop) r.flt = FAULT_UNDERFLOW;
					else begin
						sp = below;
						w = rd_word(below);
						pc = w[15:0];
					end
				end
				OP_POP, OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
					if (!can_pop) r.flt = FAULT_UNDERFLOW;
					else begin
						w = rd_word(below);
						if (op == OP_DIV && w == 0) r.flt = FAULT_DIV_ZERO;
						else begin
							sp = below;
							case (op)
								OP_POP: acc = w;
								OP_ADD: acc = acc + w;
								OP_SUB: acc = acc - w;
								OP_MUL: acc = acc * w;
								default: begin
									ma = acc[31] ? -acc : acc;
									mb = w[31] ? -w : w;
									q = ma / mb;
									acc = (acc[31] != w[31]) ? -q : q;
								end
							endcase
						end
					end
				end
				OP_PUTC: r.prn = PRINT_CHAR;
				OP_PUTI: r.prn = PRINT_NUM;
				OP_CMP: begin
					if ((md == CMP_NZ && acc != 0) || (md == CMP_LT && $signed(acc) < 0) ||
					    (md == CMP_LE && $signed(acc) <= 0) || (md == CMP_EQ && acc == 0))
						skip = 1'b1;
				end
				default: ;
			endcase
			r.acc = acc; r.pc = pc; r.sp = sp; r.bp = bp; r.skip = skip;
			pending.push_back(r);
		endfunction

		// compare one result beat with the oldest expectation
		function void check_result(vm_res_t got);
			vm_res_t e;
			beats++;
			if (pending.size() == 0) begin
				$error("unexpected result beat");
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.acc !== e.acc) begin
				$error("accum_value exp %h got %h", e.acc, got.acc); errors++;
			end
			if (got.pc !== e.pc) begin
				$error("program_counter exp %h got %h", e.pc, got.pc); errors++;
			end
			if (got.sp !== e.sp) begin
				$error("stack_pointer exp %h got %h", e.sp, got.sp); errors++;
			end
			if (got.bp !== e.bp) begin
				$error("base_pointer exp %h got %h", e.bp, got.bp); errors++;
			end
			if (got.skip !== e.skip) begin
				$error("skip_pending exp %b got %b", e.skip, got.skip); errors++;
			end
			if (got.prn !== e.prn) begin
				$error("print_kind exp %0d got %0d", e.prn, got.prn); errors++;
			end
			if (got.flt !== e.flt) begin
				$error("fault exp %0d got %0d", e.flt, got.flt); errors++;
			end
		endfunction
	endclass

	logic        clk, arst_n;
	logic        op_valid, op_stall;
	logic [3:0]  opcode;
	logic [31:0] immediate;
	logic [2:0]  sub_mode;
	logic        res_valid, res_stall;
	logic [31:0] accum_value;
	logic [15:0] program_counter, stack_pointer, base_pointer;
	logic        skip_pending;
	logic [1:0]  print_kind, fault;

	vm_scoreboard sb;
	int send_idle_pct, recv_idle_pct;
	int n_ops;

	stack_accumulator_vm_core DUT (
		.clk(clk), .arst_n(arst_n),
		.op_valid(op_valid), .op_stall(op_stall),
		.opcode(opcode), .immediate(immediate), .sub_mode(sub_mode),
		.res_valid(res_valid), .res_stall(res_stall),
		.accum_value(accum_value), .program_counter(program_counter),
		.stack_pointer(stack_pointer), .base_pointer(base_pointer),
		.skip_pending(skip_pending), .print_kind(print_kind), .fault(fault)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stall, check on every accepted beat
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.check_result({accum_value, program_counter, stack_pointer, base_pointer,
			                 skip_pending, print_t'(print_kind), fault_t'(fault)});
		res_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// send one operation beat, with random idle cycles in front
	task automatic send_op(logic [3:0] op, logic [31:0] imm, logic [2:0] md);
		while ($urandom_range(99) < send_idle_pct) begin
			op_valid <= 1'b0;
			@(posedge clk);
		end
		op_valid  <= 1'b1;
		opcode    <= op;
		immediate <= imm;
		sub_mode  <= md;
		do @(posedge clk); while (op_stall);
		sb.note_op(op, imm, md);
		n_ops++;
	endtask

	// random operation, biased towards stack traffic that stays in range
	task automatic send_random();
		logic [3:0]  op;
		logic [31:0] imm;
		logic [2:0]  md;
		int unsigned k;
		k = $urandom_range(99);
		md = 3'($urandom_range(7));
		case ($urandom_range(9))
			0: imm = 32'h8000_0000;
			1: imm = 32'h7FFF_FFFF;
			2: imm = 32'hFFFF_FFFF;
			3: imm = 32'($urandom_range(16));
			default: imm = $urandom;
		endcase
		if (k < 25) op = OP_PUSH;
		else if (k < 32) op = OP_LOAD;
		else if (k < 36) begin
			op = OP_FETCH;
			// keep fetches mostly inside the stack so data is interesting
			if ($urandom_range(1) == 0) begin
				send_op(OP_LOAD, 32'($urandom_range(STK + 64)), 3'd0);
			end
		end
		else if (k < 63) op = 4'($urandom_range(OP_POP, OP_DIV));
		else if (k < 70) op = OP_PTR;
		else if (k < 75) op = OP_JUMP;
		else if (k < 80) op = OP_CALL;
		else if (k < 85) op = OP_RET;
		else if (k < 93) op = OP_CMP;
		else if (k < 97) op = 4'($urandom_range(OP_PUTC, OP_PUTI));
		else op = 4'd15;
		if ((op == OP_PTR || op == OP_CMP) && $urandom_range(3) != 0) md = 3'($urandom_range(3));
		send_op(op, imm, md);
	endtask

	task automatic drain();
		op_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// stimulus
	initial begin
		sb = new();
		n_ops = 0;
		arst_n = 1'b0;
		op_valid = 1'b0; opcode = '0; immediate = '0; sub_mode = '0;
		send_idle_pct = 0; recv_idle_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: underflow, divide by zero, extremes, every opcode but add, sub and mul
		send_op(OP_POP, 0, 0);
		send_op(OP_RET, 0, 0);
		send_op(OP_PTR, 0, PM_POP_BP);
		send_op(OP_LOAD, 32'h8000_0000, 0);
		send_op(OP_PUSH, 0, 0);
		send_op(OP_LOAD, 32'hFFFF_FFFF, 0);
		send_op(OP_PUSH, 0, 0);
		send_op(OP_LOAD, 32'h8000_0000, 0);
		send_op(OP_DIV, 0, 0);
		send_op(OP_LOAD, 0, 0);
		send_op(OP_PUSH, 0, 0);
		send_op(OP_DIV, 0, 0);
		send_op(OP_FETCH, 0, 3'd7);
		send_op(OP_FETCH, 0, 3'd0);
		send_op(OP_FETCH, 0, 3'd2);
		send_op(OP_CMP, 0, CMP_EQ);
		send_op(OP_JUMP, 32'h7FFF_FFFF, 0);
		send_op(OP_CALL, 32'h8000_0000, 0);
		send_op(OP_PTR, 0, PM_BP_FROM_SP);
		send_op(OP_PTR, 0, PM_ACC_FROM_BP);
		send_op(OP_PTR, 0, 3'd6);
		send_op(OP_CMP, 0, 3'd5);
		send_op(OP_PUTC, 0, 0);
		send_op(OP_PUTI, 0, 0);
		send_op(4'd15, 32'hFFFF_FFFF, 3'd7);

		// hold off until the machine is idle
		drain();

		// overflow: fill the stack to the top with pushes and a base-pointer shortcut
		send_op(OP_PTR, 0, PM_SP_FROM_BP);
		while (sb.sp + 16'd4 <= STK[15:0] && sb.sp < STK[15:0]) begin
			if (sb.sp > 16'd64 && sb.sp < STK[15:0] - 16'd8) begin
				// shortcut: jump stack top via base pointer from a popped word
				send_op(OP_LOAD, 32'(STK - 8), 0);
				send_op(OP_PUSH, 0, 0);
				send_op(OP_PTR, 0, PM_POP_BP);
				send_op(OP_PTR, 0, PM_SP_FROM_BP);
			end else send_op(OP_PUSH, 0, 0);
		end
		send_op(OP_PUSH, 0, 0);
		send_op(OP_CALL, 0, 0);
		// make room, then bring base and stack top back to zero
		send_op(OP_POP, 0, 0);
		send_op(OP_LOAD, 0, 0);
		send_op(OP_PUSH, 0, 0);
		send_op(OP_PTR, 0, PM_POP_BP);
		send_op(OP_PTR, 0, PM_SP_FROM_BP);

		// random phases with different idling
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
				1: begin send_idle_pct = 78; recv_idle_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_idle_pct = 78; end
				default: begin send_idle_pct = 17; recv_idle_pct = 17; end
			endcase
			repeat (230) begin
				send_random();
				// keep the stack shallow so pops often hit real data
				if (sb.sp > 16'd256 && sb.bp <= 16'd256) begin
					send_op(OP_PTR, 0, PM_SP_FROM_BP);
				end
			end
		end

		drain();
		$display("ran %0d operations, %0d result beats checked, across four idling mixes",
		         n_ops, sb.beats);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// watchdog: memory sweep plus slow divides under heavy stalling
	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end
endmodule
